// ===== hw/rtl/moe_pkg.sv =====
// ---------------------------------------------------------------------------
// moe_pkg
// Shared types, codes and tables for the 16-bit memory operand encoder.
// ---------------------------------------------------------------------------
`default_nettype none

package moe_pkg;

    // Token kinds; codes 5..7 are all treated as an illegal token
    typedef enum logic [2:0] {
        KIND_NUMBER = 3'd0,
        KIND_PLUS   = 3'd1,
        KIND_MINUS  = 3'd2,
        KIND_REG    = 3'd3,
        KIND_CLOSE  = 3'd4,
        KIND_OTHER  = 3'd5
    } token_kind_t;

    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_PLUS  = 2'd1,
        PH_ELEM  = 2'd2,
        PH_MINUS = 2'd3
    } phase_t;

    typedef enum logic {
        RES_DONE  = 1'b0,
        RES_ERROR = 1'b1
    } result_kind_t;

    localparam logic [11:0] MASK_RESET    = 12'h027;
    localparam logic [11:0] MASK_SELECTED = 12'hA90;

    // Selected-register patterns after masking with MASK_SELECTED
    localparam logic [11:0] SEL_NONE  = 12'h000;
    localparam logic [11:0] SEL_BX_SI = 12'h210;
    localparam logic [11:0] SEL_BX_DI = 12'h810;
    localparam logic [11:0] SEL_BP_SI = 12'h280;
    localparam logic [11:0] SEL_BP_DI = 12'h880;
    localparam logic [11:0] SEL_SI    = 12'h200;
    localparam logic [11:0] SEL_DI    = 12'h800;
    localparam logic [11:0] SEL_BP    = 12'h080;
    localparam logic [11:0] SEL_BX    = 12'h010;

    localparam logic [7:0]  MODRM_DIRECT  = 8'h06;
    localparam logic [7:0]  MODRM_BP_ZERO = 8'h46;
    localparam logic [7:0]  MOD_NONE      = 8'h00;
    localparam logic [7:0]  MOD_DISP8     = 8'h40;
    localparam logic [7:0]  MOD_DISP16    = 8'h80;
    localparam logic [15:0] DISP8_POS_MAX = 16'h007F;
    localparam logic [15:0] DISP8_NEG_MIN = 16'hFF80;

    localparam int TOKEN_DATA_W  = 32;
    localparam int TOKEN_USER_W  = 3;
    localparam int RESULT_DATA_W = 40;
    localparam int RESULT_USER_W = 1;

    typedef struct packed {
        logic [11:0] mask;
        logic [15:0] disp;
        phase_t      phase;
    } parse_state_t;

    typedef struct packed {
        result_kind_t kind;
        logic [7:0]   modrm;
        logic [15:0]  disp;
        logic [15:0]  err_pos;
    } result_t;

    // Mask bits claimed by each word register (AX CX DX BX SP BP SI DI)
    function automatic logic [11:0] reg_mask(input logic [2:0] idx);
        logic [11:0] m;
        case (idx)
            3'd0:    m = 12'h001;
            3'd1:    m = 12'h002;
            3'd2:    m = 12'h004;
            3'd3:    m = 12'h058;
            3'd4:    m = 12'h020;
            3'd5:    m = 12'h0C8;
            3'd6:    m = 12'h700;
            3'd7:    m = 12'hD00;
            default: m = 12'h000;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/moe_step.sv =====
// ---------------------------------------------------------------------------
// moe_step
// Next-state and result logic for one token of a memory operand.
// ---------------------------------------------------------------------------
`default_nettype none

module moe_step (
    input  wire moe_pkg::parse_state_t state_i,
    input  wire logic [2:0]            kind_i,
    input  wire logic [15:0]           value_i,
    input  wire logic [15:0]           pos_i,
    output moe_pkg::parse_state_t      state_o,
    output logic                       has_result_o,
    output moe_pkg::result_t           result_o
);

    moe_pkg::parse_state_t reset_state;
    moe_pkg::result_t      err_res;
    logic [11:0]           rmask;
    logic [7:0]            mod_bits;
    logic [7:0]            modrm;
    logic                  after_sign;

    assign reset_state = '{mask: moe_pkg::MASK_RESET, disp: 16'h0000,
                           phase: moe_pkg::PH_START};
    assign err_res     = '{kind: moe_pkg::RES_ERROR, modrm: 8'h00, disp: 16'h0000,
                           err_pos: pos_i};
    assign rmask       = moe_pkg::reg_mask(value_i[2:0]);
    assign after_sign  = (state_i.phase == moe_pkg::PH_PLUS) ||
                         (state_i.phase == moe_pkg::PH_MINUS);

    // Mod field from displacement size, then r/m from the selected registers
    always_comb begin
        if (state_i.disp == 16'h0000) begin
            mod_bits = moe_pkg::MOD_NONE;
        end else if (state_i.disp <= moe_pkg::DISP8_POS_MAX ||
                     state_i.disp >= moe_pkg::DISP8_NEG_MIN) begin
            mod_bits = moe_pkg::MOD_DISP8;
        end else begin
            mod_bits = moe_pkg::MOD_DISP16;
        end
        case (state_i.mask & moe_pkg::MASK_SELECTED)
            moe_pkg::SEL_NONE:  modrm = moe_pkg::MODRM_DIRECT;
            moe_pkg::SEL_BX_SI: modrm = mod_bits;
            moe_pkg::SEL_BX_DI: modrm = mod_bits | 8'd1;
            moe_pkg::SEL_BP_SI: modrm = mod_bits | 8'd2;
            moe_pkg::SEL_BP_DI: modrm = mod_bits | 8'd3;
            moe_pkg::SEL_SI:    modrm = mod_bits | 8'd4;
            moe_pkg::SEL_DI:    modrm = mod_bits | 8'd5;
            moe_pkg::SEL_BP: begin
                // BP with no displacement has no mod-00 form: use disp8 of zero
                modrm = (mod_bits == moe_pkg::MOD_NONE) ? moe_pkg::MODRM_BP_ZERO
                                                        : (mod_bits | 8'd6);
            end
            moe_pkg::SEL_BX:    modrm = mod_bits | 8'd7;
            default:            modrm = mod_bits;
        endcase
    end

    always_comb begin
        state_o      = state_i;
        has_result_o = 1'b0;
        result_o     = err_res;
        case (kind_i)
            moe_pkg::KIND_NUMBER: begin
                state_o.disp  = (state_i.phase == moe_pkg::PH_MINUS) ?
                                state_i.disp - value_i : state_i.disp + value_i;
                state_o.phase = moe_pkg::PH_ELEM;
            end
            moe_pkg::KIND_PLUS, moe_pkg::KIND_MINUS: begin
                if (after_sign) begin
                    has_result_o = 1'b1;
                    state_o      = reset_state;
                end else begin
                    state_o.phase = (kind_i == moe_pkg::KIND_PLUS) ? moe_pkg::PH_PLUS
                                                                   : moe_pkg::PH_MINUS;
                end
            end
            moe_pkg::KIND_REG: begin
                if (state_i.phase == moe_pkg::PH_MINUS || value_i[15:3] != 13'd0 ||
                    (state_i.mask & rmask) != 12'h000) begin
                    has_result_o = 1'b1;
                    state_o      = reset_state;
                end else begin
                    state_o.mask  = state_i.mask | rmask;
                    state_o.phase = moe_pkg::PH_ELEM;
                end
            end
            moe_pkg::KIND_CLOSE: begin
                has_result_o = 1'b1;
                state_o      = reset_state;
                if (state_i.phase == moe_pkg::PH_ELEM) begin
                    result_o = '{kind: moe_pkg::RES_DONE, modrm: modrm,
                                 disp: state_i.disp, err_pos: 16'h0000};
                end
            end
            default: begin
                has_result_o = 1'b1;
                state_o      = reset_state;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/memory_operand_modrm_encoder_core.sv =====
// ---------------------------------------------------------------------------
// memory_operand_modrm_encoder_core
// Parses the tokens of a 16-bit memory operand and emits its ModR/M byte
// and displacement, or an error word with the offending token's column.
// ---------------------------------------------------------------------------
//
//  channel   dir   tdata (low bit up)                      tuser
//  s_axis    in    token_value, token_position (32 b)      token_kind (3 b)
//  m_axis    out   modrm_byte, displacement_word,          result_kind (1 b)
//                  error_position (40 b)
//
//  One token word per cycle while the result side is not stalled. Each word
//  is held in the input register, decoded against the parse state, and any
//  result lands in the output register.
//  Reset (aresetn low, synchronous) empties both registers and restores the
//  parse state. A stalled result word blocks the input register, which in
//  turn drops s_axis_tready once it is also full.
// ---------------------------------------------------------------------------
`default_nettype none

module memory_operand_modrm_encoder_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [15:0] token_value, [31:16] token_position
    input  wire logic [2:0]  s_axis_tuser,   // [2:0] token_kind
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // [7:0] modrm_byte, [23:8] displacement_word,
                                             // [39:24] error_position
    output logic [0:0]       m_axis_tuser    // [0] result_kind
);

    // Input register
    logic                   in_valid_reg, in_valid_next;
    logic [2:0]             in_kind_reg;
    logic [15:0]            in_value_reg;
    logic [15:0]            in_pos_reg;

    // Parse state
    moe_pkg::parse_state_t  state_reg, state_next;

    // Output register
    logic                   out_valid_reg, out_valid_next;
    moe_pkg::result_t       out_reg;

    moe_pkg::parse_state_t  step_state;
    moe_pkg::result_t       step_result;
    logic                   step_has_result;
    logic                   advance;
    logic                   s_accept;

    moe_step u_step (
        .state_i      (state_reg),
        .kind_i       (in_kind_reg),
        .value_i      (in_value_reg),
        .pos_i        (in_pos_reg),
        .state_o      (step_state),
        .has_result_o (step_has_result),
        .result_o     (step_result)
    );

    // Advance the held token once the result slot is free or being emptied
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_comb begin
        in_valid_next  = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        state_next     = advance ? step_state : state_reg;
        if (advance && step_has_result) begin
            out_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{mask: moe_pkg::MASK_RESET, disp: 16'h0000,
                               phase: moe_pkg::PH_START};
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
        end
    end

    // Payload registers: input on handshake only, output when a result is produced
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_kind_reg  <= s_axis_tuser;
            in_value_reg <= s_axis_tdata[15:0];
            in_pos_reg   <= s_axis_tdata[31:16];
        end
        if (advance && step_has_result) begin
            out_reg <= step_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.err_pos, out_reg.disp, out_reg.modrm};
    assign m_axis_tuser  = out_reg.kind;

`ifndef SYNTHESIS
    // Forbidden registers stay marked in the mask at all times
    a_mask_forbidden: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.mask & moe_pkg::MASK_RESET) == moe_pkg::MASK_RESET)
        else $error("forbidden register bits lost from mask");

    // An error word carries neither ModR/M nor displacement
    a_error_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser[0]) |->
            (m_axis_tdata[23:0] == 24'h000000))
        else $error("error word with encoding bits set");

    // A completed operand reports no error position
    a_done_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[39:24] == 16'h0000))
        else $error("operand word with error position set");

    // Any emitted result returns the parser to its start
    a_result_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && step_has_result) |=>
            (state_reg.phase == moe_pkg::PH_START && state_reg.disp == 16'h0000))
        else $error("parse state not restored after result");
`endif

endmodule

`default_nettype wire

// ===== sim/tb_memory_operand_modrm_encoder_core.sv =====
// ---------------------------------------------------------------------------
// tb_memory_operand_modrm_encoder_core
// Self-checking bench for the memory operand ModR/M encoder. A short table of
// hand-picked tokens covers the boundary values, the error cases and the
// BP/direct-address encodings. Random operands follow, mostly legal ones with
// some broken operands and some loose tokens mixed in. Every result word is
// compared with an in-bench model of the parser, with random back-pressure
// and random gaps on both streams.
// ---------------------------------------------------------------------------
module tb_memory_operand_modrm_encoder_core;
    import moe_pkg::*;

    localparam int PERIOD       = 8;
    localparam int RESET_CYCLES = 8;
    localparam int ITEM_TARGET  = 450;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AT      = 15;
    localparam int PAUSE_AT     = 30;
    localparam int DRAIN_CYCLES = 16;
    localparam int LIMIT_CYCLES = 500000;

    // Token kinds the package leaves unnamed; both are illegal tokens
    localparam logic [2:0] KIND_RSVD6 = 3'd6;
    localparam logic [2:0] KIND_RSVD7 = 3'd7;

    // Word register indexes
    localparam logic [15:0] R_AX = 16'd0;
    localparam logic [15:0] R_CX = 16'd1;
    localparam logic [15:0] R_DX = 16'd2;
    localparam logic [15:0] R_BX = 16'd3;
    localparam logic [15:0] R_SP = 16'd4;
    localparam logic [15:0] R_BP = 16'd5;
    localparam logic [15:0] R_SI = 16'd6;
    localparam logic [15:0] R_DI = 16'd7;

    // r/m field values for each base/index pair
    localparam logic [7:0] RM_BX_SI = 8'd0;
    localparam logic [7:0] RM_BX_DI = 8'd1;
    localparam logic [7:0] RM_BP_SI = 8'd2;
    localparam logic [7:0] RM_BP_DI = 8'd3;
    localparam logic [7:0] RM_SI    = 8'd4;
    localparam logic [7:0] RM_DI    = 8'd5;
    localparam logic [7:0] RM_BP    = 8'd6;
    localparam logic [7:0] RM_BX    = 8'd7;

    // Mask bits each register claims, register 0 in the lowest 12 bits
    localparam logic [95:0] REG_CLAIM = {12'hD00, 12'h700, 12'h0C8, 12'h020,
                                         12'h058, 12'h004, 12'h002, 12'h001};

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] value;
        logic [15:0] pos;
    } token_t;

    typedef struct packed {
        token_t  tok;
        bit      typed;
        result_t res;
    } directed_row_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;   // [15:0] token_value, [31:16] token_position
    logic [2:0]  s_axis_tuser  = '0;   // [2:0] token_kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;         // [7:0] modrm_byte, [23:8] displacement_word,
                                       // [39:24] error_position
    logic [0:0]  m_axis_tuser;         // [0] result_kind

    // Parser model state
    logic [11:0] sel_mask  = MASK_RESET;
    logic [15:0] acc_disp  = '0;
    phase_t      acc_phase = PH_START;

    result_t       pending_results[$];
    directed_row_t directed_rows[$];
    token_t        operand_tokens[$];
    int            mismatch_count = 0;
    int            sent_count     = 0;
    int            burst_left     = 0;
    bit            tight          = 1'b0;
    bit            hold_req       = 1'b0;

    memory_operand_modrm_encoder_core i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #(PERIOD / 2) aclk = ~aclk;

    // Hard stop in case the block hangs
    initial begin
        #(LIMIT_CYCLES * PERIOD);
        $display("Mismatches found");
        $finish;
    end

    // -----------------------------------------------------------------------
    // Parser model
    // -----------------------------------------------------------------------
    function automatic result_t err_at(input logic [15:0] pos);
        result_t r;
        r.kind    = RES_ERROR;
        r.modrm   = '0;
        r.disp    = '0;
        r.err_pos = pos;
        return r;
    endfunction

    function automatic result_t done_with(input logic [7:0] modrm, input logic [15:0] disp);
        result_t r;
        r.kind    = RES_DONE;
        r.modrm   = modrm;
        r.disp    = disp;
        r.err_pos = '0;
        return r;
    endfunction

    function automatic logic [7:0] modrm_for(input logic [11:0] mask, input logic [15:0] disp);
        logic [7:0] m;
        if (disp == '0) begin
            m = MOD_NONE;
        end else if (disp <= DISP8_POS_MAX || disp >= DISP8_NEG_MIN) begin
            m = MOD_DISP8;
        end else begin
            m = MOD_DISP16;
        end
        case (mask & MASK_SELECTED)
            SEL_NONE:  m = MODRM_DIRECT;
            SEL_BX_SI: m = m | RM_BX_SI;
            SEL_BX_DI: m = m | RM_BX_DI;
            SEL_BP_SI: m = m | RM_BP_SI;
            SEL_BP_DI: m = m | RM_BP_DI;
            SEL_SI:    m = m | RM_SI;
            SEL_DI:    m = m | RM_DI;
            SEL_BX:    m = m | RM_BX;
            SEL_BP: begin
                // BP with no displacement has no mod 00 form: use a zero disp8
                if (m == MOD_NONE) m = MODRM_BP_ZERO;
                else m = m | RM_BP;
            end
            default: ;
        endcase
        return m;
    endfunction

    // Advance the model by one token; returns 1 when the token ends the operand
    function automatic bit parse_token(input token_t t, output result_t res);
        logic [11:0] claim;
        bit          fault;
        bit          closed;
        fault  = 1'b0;
        closed = 1'b0;
        res    = '0;
        case (t.kind)
            KIND_NUMBER: begin
                if (acc_phase == PH_MINUS) acc_disp = acc_disp - t.value;
                else acc_disp = acc_disp + t.value;
                acc_phase = PH_ELEM;
            end
            KIND_PLUS, KIND_MINUS: begin
                if (acc_phase == PH_PLUS || acc_phase == PH_MINUS) begin
                    fault = 1'b1;
                end else if (t.kind == KIND_PLUS) begin
                    acc_phase = PH_PLUS;
                end else begin
                    acc_phase = PH_MINUS;
                end
            end
            KIND_REG: begin
                claim = REG_CLAIM[t.value[2:0] * 12 +: 12];
                if (acc_phase == PH_MINUS || t.value > R_DI || (sel_mask & claim) != '0) begin
                    fault = 1'b1;
                end else begin
                    sel_mask  = sel_mask | claim;
                    acc_phase = PH_ELEM;
                end
            end
            KIND_CLOSE: begin
                if (acc_phase != PH_ELEM) begin
                    fault = 1'b1;
                end else begin
                    res    = done_with(modrm_for(sel_mask, acc_disp), acc_disp);
                    closed = 1'b1;
                end
            end
            default: fault = 1'b1;
        endcase
        if (fault) res = err_at(t.pos);
        if (fault || closed) begin
            sel_mask  = MASK_RESET;
            acc_disp  = '0;
            acc_phase = PH_START;
        end
        return fault || closed;
    endfunction

    // -----------------------------------------------------------------------
    // Stimulus helpers
    // -----------------------------------------------------------------------
    function automatic int gap_len();
        if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic token_t mk_token(input logic [2:0] kind, input logic [15:0] value);
        token_t t;
        t.kind  = kind;
        t.value = value;
        t.pos   = 16'($urandom_range(0, 65535));
        return t;
    endfunction

    function automatic token_t any_token();
        logic [15:0] v;
        if ($urandom_range(0, 1) == 0) v = 16'($urandom_range(0, 15));
        else v = 16'($urandom_range(0, 65535));
        return mk_token(3'($urandom_range(0, 7)), v);
    endfunction

    function automatic logic [15:0] pick_number();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'($urandom_range(1, 127));
            2:       return $urandom_range(0, 1) ? 16'h007F : 16'h0080;
            3:       return $urandom_range(0, 1) ? 16'hFF7F : 16'hFF80;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic directed_row_t plain(input logic [2:0] kind, input logic [15:0] value,
                                            input logic [15:0] pos);
        directed_row_t r;
        r.tok   = '{kind, value, pos};
        r.typed = 1'b0;
        r.res   = '0;
        return r;
    endfunction

    function automatic directed_row_t checked(input logic [2:0] kind, input logic [15:0] value,
                                              input logic [15:0] pos, input result_t res);
        directed_row_t r;
        r = plain(kind, value, pos);
        r.typed = 1'b1;
        r.res   = res;
        return r;
    endfunction

    // Offer one token word from a falling edge, hold it until accepted, and
    // queue what it should produce. Returns at the falling edge after the accept.
    task automatic send_token(input token_t t, input bit typed, input result_t typed_res);
        int      gap;
        bit      has;
        result_t r;
        gap = 0;
        if (burst_left > 0) begin
            burst_left = burst_left - 1;
        end else if (!tight && $urandom_range(0, 99) < 35) begin
            gap = gap_len();
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {t.pos, t.value};
        s_axis_tuser  <= t.kind;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        has = parse_token(t, r);
        if (typed) r = typed_res;
        if (has) pending_results.push_back(r);
        sent_count = sent_count + 1;
        @(negedge aclk);
    endtask

    // Build one legal operand: a legal base/index set and up to three numbers in
    // random order, with optional signs, closed by the bracket
    task automatic build_operand();
        token_t elems[$];
        token_t e;
        int     n_nums;
        int     roll;
        elems.delete();
        operand_tokens.delete();
        case ($urandom_range(0, 8))
            1: elems.push_back(mk_token(KIND_REG, R_BX));
            2: elems.push_back(mk_token(KIND_REG, R_BP));
            3: elems.push_back(mk_token(KIND_REG, R_SI));
            4: elems.push_back(mk_token(KIND_REG, R_DI));
            5: begin
                elems.push_back(mk_token(KIND_REG, R_BX));
                elems.push_back(mk_token(KIND_REG, R_SI));
            end
            6: begin
                elems.push_back(mk_token(KIND_REG, R_BX));
                elems.push_back(mk_token(KIND_REG, R_DI));
            end
            7: begin
                elems.push_back(mk_token(KIND_REG, R_BP));
                elems.push_back(mk_token(KIND_REG, R_SI));
            end
            8: begin
                elems.push_back(mk_token(KIND_REG, R_BP));
                elems.push_back(mk_token(KIND_REG, R_DI));
            end
            default: ;
        endcase
        if (elems.size() == 2 && $urandom_range(0, 1) == 1) begin
            e = elems.pop_front();
            elems.push_back(e);
        end
        n_nums = $urandom_range(0, 3);
        if (elems.size() == 0 && n_nums == 0) n_nums = 1;
        repeat (n_nums) elems.insert($urandom_range(0, elems.size()),
                                     mk_token(KIND_NUMBER, pick_number()));
        foreach (elems[i]) begin
            roll = $urandom_range(0, 99);
            if (i == 0 ? roll >= 70 : roll < 75) begin
                // Never put a minus in front of a register
                if (elems[i].kind == KIND_NUMBER && $urandom_range(0, 2) == 0) begin
                    operand_tokens.push_back(mk_token(KIND_MINUS,
                                                      16'($urandom_range(0, 65535))));
                end else begin
                    operand_tokens.push_back(mk_token(KIND_PLUS,
                                                      16'($urandom_range(0, 65535))));
                end
            end
            operand_tokens.push_back(elems[i]);
        end
        operand_tokens.push_back(mk_token(KIND_CLOSE, 16'($urandom_range(0, 65535))));
    endtask

    // -----------------------------------------------------------------------
    // Result side: random back-pressure, with a long hold on request
    // -----------------------------------------------------------------------
    initial begin : rx_throttle
        int hold_left;
        int quiet_left;
        hold_left  = 0;
        quiet_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left = hold_left - 1;
            end else if (quiet_left > 0) begin
                m_axis_tready <= 1'b1;
                quiet_left = quiet_left - 1;
            end else if ($urandom_range(0, 99) < 4) begin
                // Stretch with no stalls at all
                m_axis_tready <= 1'b1;
                quiet_left = $urandom_range(20, 80);
            end else if ($urandom_range(0, 99) < 25) begin
                m_axis_tready <= 1'b0;
                hold_left = gap_len() - 1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Compare every accepted result word with the oldest expectation
    always @(posedge aclk) begin : result_check
        result_t got;
        result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.kind    = result_kind_t'(m_axis_tuser[0]);
            got.modrm   = m_axis_tdata[7:0];
            got.disp    = m_axis_tdata[23:8];
            got.err_pos = m_axis_tdata[39:24];
            if (pending_results.size() == 0) begin
                $error("result word %h/%h arrived with nothing expected",
                       m_axis_tuser, m_axis_tdata);
                mismatch_count = mismatch_count + 1;
            end else begin
                want = pending_results.pop_front();
                if (got.kind != want.kind) begin
                    $error("result_kind: expected %0d, actual %0d", want.kind, got.kind);
                    mismatch_count = mismatch_count + 1;
                end
                if (got.modrm != want.modrm) begin
                    $error("modrm_byte: expected %h, actual %h", want.modrm, got.modrm);
                    mismatch_count = mismatch_count + 1;
                end
                if (got.disp != want.disp) begin
                    $error("displacement_word: expected %h, actual %h", want.disp, got.disp);
                    mismatch_count = mismatch_count + 1;
                end
                if (got.err_pos != want.err_pos) begin
                    $error("error_position: expected %h, actual %h",
                           want.err_pos, got.err_pos);
                    mismatch_count = mismatch_count + 1;
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Main sequence
    // -----------------------------------------------------------------------
    initial begin : stimulus
        int op_count;
        int broken;
        op_count = 0;

        // Close at the very start
        directed_rows.push_back(checked(KIND_CLOSE, 16'h0000, 16'hFFFF, err_at(16'hFFFF)));
        // Largest number alone: direct address
        directed_rows.push_back(plain(KIND_NUMBER, 16'hFFFF, 16'h0000));
        directed_rows.push_back(checked(KIND_CLOSE, 16'hFFFF, 16'h0001,
                                        done_with(MODRM_DIRECT, 16'hFFFF)));
        // BP alone with nothing added
        directed_rows.push_back(plain(KIND_REG, R_BP, 16'h0010));
        directed_rows.push_back(checked(KIND_CLOSE, 16'h0000, 16'h0011,
                                        done_with(MODRM_BP_ZERO, 16'h0000)));
        // Register after a minus
        directed_rows.push_back(plain(KIND_MINUS, 16'h0000, 16'h00FF));
        directed_rows.push_back(checked(KIND_REG, R_SI, 16'h0100, err_at(16'h0100)));
        // Sign after a sign
        directed_rows.push_back(plain(KIND_PLUS, 16'hFFFF, 16'h0202));
        directed_rows.push_back(checked(KIND_MINUS, 16'hFFFF, 16'h0203, err_at(16'h0203)));
        // Close straight after a sign
        directed_rows.push_back(plain(KIND_PLUS, 16'h0000, 16'h0304));
        directed_rows.push_back(checked(KIND_CLOSE, 16'h0000, 16'h0305, err_at(16'h0305)));
        // Illegal token kinds
        directed_rows.push_back(checked(KIND_RSVD7, 16'hFFFF, 16'h1234, err_at(16'h1234)));
        directed_rows.push_back(checked(KIND_RSVD6, 16'h0000, 16'h0000, err_at(16'h0000)));
        directed_rows.push_back(checked(KIND_OTHER, 16'h5555, 16'h8000, err_at(16'h8000)));
        // Register index out of range, then a forbidden register
        directed_rows.push_back(checked(KIND_REG, 16'hFFFF, 16'h4321, err_at(16'h4321)));
        directed_rows.push_back(checked(KIND_REG, R_AX, 16'h0007, err_at(16'h0007)));
        // The other registers that can never address memory
        directed_rows.push_back(checked(KIND_REG, R_CX, 16'h0008, err_at(16'h0008)));
        directed_rows.push_back(checked(KIND_REG, R_DX, 16'h0009, err_at(16'h0009)));
        directed_rows.push_back(checked(KIND_REG, R_SP, 16'h000A, err_at(16'h000A)));
        // BX with BP is not an 8086 pair
        directed_rows.push_back(plain(KIND_REG, R_BX, 16'h0020));
        directed_rows.push_back(plain(KIND_REG, R_BP, 16'h0021));
        // BX+SI+0x80: first value needing a 16-bit displacement
        directed_rows.push_back(plain(KIND_REG, R_BX, 16'h0030));
        directed_rows.push_back(plain(KIND_PLUS, 16'h0000, 16'h0031));
        directed_rows.push_back(plain(KIND_REG, R_SI, 16'h0032));
        directed_rows.push_back(plain(KIND_PLUS, 16'h0000, 16'h0033));
        directed_rows.push_back(plain(KIND_NUMBER, 16'h0080, 16'h0034));
        directed_rows.push_back(plain(KIND_CLOSE, 16'h0000, 16'h0035));
        // Negative number, then a register with no sign between them
        directed_rows.push_back(plain(KIND_MINUS, 16'h0000, 16'h0040));
        directed_rows.push_back(plain(KIND_NUMBER, 16'h0001, 16'h0041));
        directed_rows.push_back(plain(KIND_REG, R_DI, 16'h0042));
        directed_rows.push_back(plain(KIND_CLOSE, 16'h0000, 16'h0043));

        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i]) send_token(directed_rows[i].tok, directed_rows[i].typed,
                                              directed_rows[i].res);

        while (sent_count < ITEM_TARGET) begin
            op_count = op_count + 1;

            if (op_count == HOLD_AT) begin
                // Stall the result side and keep offering error tokens until
                // the block backs up into its input
                s_axis_tvalid <= 1'b0;
                @(posedge aclk);
                hold_req = 1'b1;
                @(negedge aclk);
                tight = 1'b1;
                repeat (10) send_token(mk_token(KIND_OTHER, 16'($urandom_range(0, 65535))),
                                       1'b0, '0);
                tight = 1'b0;
            end

            if (op_count == PAUSE_AT) begin
                // Hold the sender until every result has drained
                s_axis_tvalid <= 1'b0;
                while (pending_results.size() != 0) @(negedge aclk);
            end

            if (burst_left == 0 && $urandom_range(0, 9) == 0) burst_left = $urandom_range(30, 60);

            if ($urandom_range(0, 19) == 0) begin
                // Loose tokens of any kind and value
                operand_tokens.delete();
                repeat ($urandom_range(1, 3)) operand_tokens.push_back(any_token());
            end else begin
                build_operand();
                broken = $urandom_range(0, 99);
                if (broken < 5) begin
                    // Drop the close so this operand runs into the next one
                    void'(operand_tokens.pop_back());
                end else if (broken < 15) begin
                    operand_tokens[$urandom_range(0, operand_tokens.size() - 1)] = any_token();
                end
            end

            foreach (operand_tokens[i]) send_token(operand_tokens[i], 1'b0, '0);
        end

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/moe_pkg.sv
hw/rtl/moe_step.sv
hw/rtl/memory_operand_modrm_encoder_core.sv
sim/tb_memory_operand_modrm_encoder_core.sv
